>>> rtl/i2c_bit_level_master_core_defines.svh
// Assertion macros used by the top-level design file.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH

// The consequent must hold on every clock edge at which the antecedent holds.
`define I2CBM_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold outside reset.
`define I2CBM_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`endif

>>> rtl/i2cbm_pkg.sv
package i2cbm_pkg;

  localparam int unsigned CfgWidth        = 16;
  localparam int unsigned PhaseDelayReset = 300;
  localparam int unsigned StepWidth       = 5;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_RSTART = 3'd1,
    OP_STOP   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4,
    OP_IDLE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ACT_SDA0,
    ACT_SDA1,
    ACT_SCL0,
    ACT_SCL1,
    ACT_SDA_BIT,
    ACT_SAMPLE_ACK,
    ACT_SAMPLE_BIT,
    ACT_SDA_ACK
  } act_e;

  typedef struct packed {
    logic       cmd_ok;
    op_e        op;
    logic [7:0] tx_byte;
    logic       last_read;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
  } result_t;

  function automatic logic [1:0] mod3(input logic [StepWidth-1:0] v);
    logic [StepWidth-1:0] r;
    begin
      r = v;
      if (r >= 5'd24) r = r - 5'd24;
      if (r >= 5'd12) r = r - 5'd12;
      if (r >= 5'd6) r = r - 5'd6;
      if (r >= 5'd3) r = r - 5'd3;
      return r[1:0];
    end
  endfunction

  function automatic logic [StepWidth-1:0] last_step(input op_e op);
    case (op)
      OP_START:  return 5'd1;
      OP_RSTART: return 5'd3;
      OP_STOP:   return 5'd2;
      default:   return 5'd28;
    endcase
  endfunction

  function automatic act_e action_of(input op_e op, input logic [StepWidth-1:0] s);
    logic [StepWidth-1:0] k;
    begin
      k = '0;
      case (op)
        OP_START: begin
          return (s == 5'd0) ? ACT_SDA0 : ACT_SCL0;
        end
        OP_RSTART: begin
          case (s[1:0])
            2'd0:    return ACT_SDA1;
            2'd1:    return ACT_SCL1;
            2'd2:    return ACT_SDA0;
            default: return ACT_SCL0;
          endcase
        end
        OP_STOP: begin
          if (s == 5'd0) return ACT_SDA0;
          if (s == 5'd1) return ACT_SCL1;
          return ACT_SDA1;
        end
        OP_WRITE: begin
          if (s < 5'd24) begin
            case (mod3(s))
              2'd0:    return ACT_SDA_BIT;
              2'd1:    return ACT_SCL1;
              default: return ACT_SCL0;
            endcase
          end
          k = s - 5'd24;
          case (k)
            5'd0:    return ACT_SDA1;
            5'd1:    return ACT_SCL1;
            5'd2:    return ACT_SAMPLE_ACK;
            5'd3:    return ACT_SCL0;
            default: return ACT_SDA0;
          endcase
        end
        default: begin
          if (s == 5'd0) return ACT_SDA1;
          if (s == 5'd1) return ACT_SCL0;
          if (s < 5'd26) begin
            case (mod3(s - 5'd2))
              2'd0:    return ACT_SCL1;
              2'd1:    return ACT_SAMPLE_BIT;
              default: return ACT_SCL0;
            endcase
          end
          k = s - 5'd26;
          case (k)
            5'd0:    return ACT_SDA_ACK;
            5'd1:    return ACT_SCL1;
            default: return ACT_SCL0;
          endcase
        end
      endcase
    end
  endfunction

endpackage

>>> rtl/i2cbm_fifo.sv
module i2cbm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/i2cbm_front.sv
module i2cbm_front
  import i2cbm_pkg::*;
(
  input  logic       push_i,
  input  logic       cmd_valid_i,
  input  logic [2:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       last_read_i,
  input  logic       sda_sample_i,
  output logic       mid_push_o,
  output tick_t      tick_o
);

  op_e op;

  always_comb begin
    case (func_i)
      3'd0:    op = OP_START;
      3'd1:    op = OP_RSTART;
      3'd2:    op = OP_STOP;
      3'd3:    op = OP_WRITE;
      3'd4:    op = OP_READ;
      default: op = OP_IDLE;
    endcase
  end

  assign mid_push_o        = push_i;
  assign tick_o.cmd_ok     = cmd_valid_i && (op != OP_IDLE);
  assign tick_o.op         = op;
  assign tick_o.tx_byte    = tx_byte_i;
  assign tick_o.last_read  = last_read_i;
  assign tick_o.sda_sample = sda_sample_i;

endmodule

>>> rtl/i2cbm_back.sv
module i2cbm_back
  import i2cbm_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  input  logic                tick_valid_i,
  input  tick_t               tick_i,
  output logic                tick_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output result_t             res_o
);

  logic [CfgWidth-1:0]    phase_delay_q;
  logic [31:0]            delay_ext;
  logic [DELAY_WIDTH-1:0] delay;
  logic [DELAY_WIDTH-1:0] timer_q, timer_d, timer_inc;
  logic [StepWidth-1:0]   step_q, step_d;
  op_e                    op_q, op_d;
  logic [7:0]             shift_q, shift_d;
  logic [7:0]             read_q, read_d;
  logic                   ack_q, ack_d;
  logic                   nreq_q, nreq_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   go, fire, finish, done;
  act_e                   act;

  assign go         = tick_valid_i && !res_full_i;
  assign tick_pop_o = go;
  assign res_push_o = go;

  assign delay_ext = 32'(phase_delay_q);
  assign delay     = delay_ext[DELAY_WIDTH-1:0];
  assign timer_inc = timer_q + DELAY_WIDTH'(1);
  assign fire      = (op_q != OP_IDLE) && (timer_inc >= delay);
  assign finish    = fire && (step_q >= last_step(op_q));
  assign act       = action_of(op_q, step_q);

  always_comb begin
    op_d = op_q;
    case (op_q)
      OP_IDLE: begin
        if (tick_i.cmd_ok) begin
          op_d = tick_i.op;
        end
      end
      default: begin
        if (finish) begin
          op_d = OP_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    timer_d = timer_q;
    step_d  = step_q;
    shift_d = shift_q;
    read_d  = read_q;
    ack_d   = ack_q;
    nreq_d  = nreq_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;
    if (op_q == OP_IDLE) begin
      if (tick_i.cmd_ok) begin
        step_d  = '0;
        timer_d = '0;
        if (tick_i.op == OP_WRITE) begin
          shift_d = tick_i.tx_byte;
        end
        if (tick_i.op == OP_READ) begin
          shift_d = '0;
          nreq_d  = tick_i.last_read;
        end
      end
    end else if (fire) begin
      timer_d = '0;
      case (act)
        ACT_SDA0: sda_d = 1'b0;
        ACT_SDA1: sda_d = 1'b1;
        ACT_SCL0: scl_d = 1'b0;
        ACT_SCL1: scl_d = 1'b1;
        ACT_SDA_BIT: begin
          sda_d   = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
        end
        ACT_SAMPLE_ACK: ack_d = tick_i.sda_sample;
        ACT_SAMPLE_BIT: shift_d = {shift_q[6:0], tick_i.sda_sample};
        default: sda_d = nreq_q;
      endcase
      if (finish) begin
        if (op_q == OP_READ) begin
          read_d = shift_d;
        end
        step_d = '0;
        done   = 1'b1;
      end else begin
        step_d = step_q + StepWidth'(1);
      end
    end else begin
      timer_d = timer_inc;
    end
  end

  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy_res    = (op_d != OP_IDLE);
  assign res_o.done_res    = done;
  assign res_o.rx_byte     = read_d;
  assign res_o.nack        = ack_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_delay_q <= CfgWidth'(PhaseDelayReset);
    end else if (cfg_we_i) begin
      phase_delay_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      timer_q <= '0;
      step_q  <= '0;
      shift_q <= '0;
      read_q  <= '0;
      ack_q   <= 1'b0;
      nreq_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (go) begin
      op_q    <= op_d;
      timer_q <= timer_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      read_q  <= read_d;
      ack_q   <= ack_d;
      nreq_q  <= nreq_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

>>> rtl/i2c_bit_level_master_core.sv
// Open-drain I2C master bit engine. Every word pushed is one timer tick that may carry a
// command (start, repeated start, stop, write byte, read byte) and the sampled SDA level, and
// every pushed word yields exactly one result word with the SCL and SDA drive levels, busy,
// done, the last received byte and the write acknowledge level. A command is taken only while
// the engine is idle, and each line action follows phase_delay ticks after the previous one.
// The engine takes one word per clock cycle while the result queue is not full; its state loop
// advances one tick per word taken. A pushed word is decoded into a two-entry queue, which the
// engine pops while the result queue has room; results wait in a two-entry result queue.
// The configuration channel is always ready and must only be written while no word is pending.
`include "i2c_bit_level_master_core_defines.svh"

module i2c_bit_level_master_core
  import i2cbm_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                cmd_valid_i,
  input  logic [2:0]          func_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                last_read_i,
  input  logic                sda_sample_i,
  output logic                empty,
  input  logic                pop,
  output logic                scl_release_o,
  output logic                sda_release_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          rx_byte_o,
  output logic                nack_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  tick_t   front_tick, mid_tick;
  result_t back_res, out_res;
  logic    mid_push, mid_empty, mid_pop;
  logic    back_push, out_full;

  assign cfg_ready_o = 1'b1;

  i2cbm_front u_front (
    .push_i      (push),
    .cmd_valid_i (cmd_valid_i),
    .func_i      (func_i),
    .tx_byte_i   (tx_byte_i),
    .last_read_i (last_read_i),
    .sda_sample_i(sda_sample_i),
    .mid_push_o  (mid_push),
    .tick_o      (front_tick)
  );

  i2cbm_fifo #(
    .WIDTH($bits(tick_t)),
    .DEPTH(2)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(front_tick),
    .full_o (full),
    .pop_i  (mid_pop),
    .rdata_o(mid_tick),
    .empty_o(mid_empty)
  );

  i2cbm_back #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .tick_valid_i(!mid_empty),
    .tick_i      (mid_tick),
    .tick_pop_o  (mid_pop),
    .res_full_i  (out_full),
    .res_push_o  (back_push),
    .res_o       (back_res)
  );

  i2cbm_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_push),
    .wdata_i(back_res),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_res),
    .empty_o(empty)
  );

  assign scl_release_o = out_res.scl_release;
  assign sda_release_o = out_res.sda_release;
  assign busy_res_o    = out_res.busy_res;
  assign done_res_o    = out_res.done_res;
  assign rx_byte_o     = out_res.rx_byte;
  assign nack_o        = out_res.nack;

  `I2CBM_ASSERT_IMPLY(a_push_not_full, clk_i, rst_ni, back_push, !out_full, "Result word lost.")
  `I2CBM_ASSERT_NEVER(a_pop_push_pair, clk_i, rst_ni, mid_pop != back_push, "Tick without result.")
  `I2CBM_ASSERT_IMPLY(a_done_not_busy, clk_i, rst_ni, !empty && done_res_o, !busy_res_o, "Done while busy.")

endmodule
